// ----- rtl/scp_pkg.sv -----
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants of the scan-count pair filter: id and counter
// widths, the counter memory word, sweep control and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

  localparam int NUM_SETS    = 4096;
  localparam int COUNT_WIDTH = 13;
  localparam int ID_W        = 12;
  localparam int THR_W       = 13;
  localparam int ADDR_W      = $clog2(NUM_SETS);
  // Width of the probe generation mark kept next to each counter
  localparam int EPOCH_W     = 16;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};
  localparam logic [ADDR_W-1:0]      ADDR_LAST = ADDR_W'(NUM_SETS - 1);
  localparam logic [THR_W-1:0]       THR_RESET = THR_W'(1);

  typedef logic [ID_W-1:0]        id_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [EPOCH_W-1:0]     epoch_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // One counter entry: generation mark and count
  typedef struct packed {
    epoch_t epoch;
    cnt_t   count;
  } mem_word_t;

  // Candidate pair
  typedef struct packed {
    id_t pair_low;
    id_t pair_high;
  } pair_t;

  // Sweep sequencer states
  typedef enum logic [1:0] {
    SWP_RUN,
    SWP_WAIT,
    SWP_SCAN,
    SWP_DRAIN
  } swp_state_t;

  // Sweep sequencer control toward the counter memory
  typedef struct packed {
    logic      busy;
    logic      rd_en;
    addr_t     rd_addr;
    logic      wr_en;
    addr_t     wr_addr;
    mem_word_t wr_data;
  } swp_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/scp_if.sv -----
// ----------------------------------------------------------------------------
// scp_if
// Valid/ready channels of the pair filter: entry input, pair output and the
// threshold write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface scp_in_if;
  import scp_pkg::*;

  logic valid;
  logic ready;
  logic new_probe;
  id_t  probe_id;
  id_t  other_id;

  modport source (output valid, output new_probe, output probe_id, output other_id,
                  input ready);
  modport sink (input valid, input new_probe, input probe_id, input other_id,
                output ready);
endinterface

interface scp_out_if;
  import scp_pkg::*;

  logic valid;
  logic ready;
  id_t  pair_low;
  id_t  pair_high;

  modport source (output valid, output pair_low, output pair_high, input ready);
  modport sink (input valid, input pair_low, input pair_high, output ready);
endinterface

interface scp_cfg_if;
  import scp_pkg::*;

  logic             valid;
  logic             ready;
  logic [THR_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/scp_count_ram.sv -----
// ----------------------------------------------------------------------------
// scp_count_ram
// Counter memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_count_ram (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire scp_pkg::addr_t     waddr,
  input  wire scp_pkg::mem_word_t wdata,
  input  wire logic               re,
  input  wire scp_pkg::addr_t     raddr,
  output scp_pkg::mem_word_t      rdata
);
  import scp_pkg::*;

  mem_word_t mem [NUM_SETS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scp_sweep.sv -----
// ----------------------------------------------------------------------------
// scp_sweep
// Memory sweep sequencer. After reset it zeroes every counter; when the probe
// generation mark is about to come back around it rewrites every stale entry
// as a zero count of the current generation.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_sweep (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire scp_pkg::epoch_t    epoch,
  input  wire scp_pkg::mem_word_t rd_data,
  output scp_pkg::swp_ctl_t       ctl
);
  import scp_pkg::*;

  swp_state_t state_r, state_nxt;
  addr_t      cnt_r, cnt_nxt;
  logic       force_r, force_nxt;
  logic       wv_r, wv_nxt;
  addr_t      waddr_r;
  logic       stale;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SWP_SCAN;
      cnt_r   <= '0;
      force_r <= 1'b1;
      wv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      force_r <= force_nxt;
      wv_r    <= wv_nxt;
    end
  end

  // Address of the read issued last cycle, written back this cycle
  always_ff @(posedge clk) begin
    waddr_r <= cnt_r;
  end

  assign stale = (rd_data.epoch != epoch);

  // Next state and memory control
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    force_nxt   = force_r;
    wv_nxt      = 1'b0;
    ctl.busy    = 1'b1;
    ctl.rd_en   = 1'b0;
    ctl.rd_addr = cnt_r;
    ctl.wr_en   = wv_r && (force_r || stale);
    ctl.wr_addr = waddr_r;
    ctl.wr_data = '{epoch: epoch, count: '0};
    case (state_r)
      SWP_RUN: begin
        ctl.busy = 1'b0;
        if (start) begin
          state_nxt = SWP_WAIT;
        end
      end
      SWP_WAIT: begin
        // let the last entry's write land first
        cnt_nxt   = '0;
        state_nxt = SWP_SCAN;
      end
      SWP_SCAN: begin
        ctl.rd_en = 1'b1;
        wv_nxt    = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == ADDR_LAST) begin
          state_nxt = SWP_DRAIN;
        end
      end
      SWP_DRAIN: begin
        force_nxt = 1'b0;
        cnt_nxt   = '0;
        state_nxt = SWP_RUN;
      end
      default: begin
        state_nxt = SWP_RUN;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/scp_result_fifo.sv -----
// ----------------------------------------------------------------------------
// scp_result_fifo
// Two-entry result queue in front of the pair output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_result_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire scp_pkg::pair_t push_data,
  output logic [1:0]          occ,
  output logic                pop,
  scp_out_if.source           out_bus
);
  import scp_pkg::*;

  pair_t      slot_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] occ_r;

  assign occ               = occ_r;
  assign out_bus.valid     = (occ_r != 2'd0);
  assign out_bus.pair_low  = slot_r[rptr_r].pair_low;
  assign out_bus.pair_high = slot_r[rptr_r].pair_high;
  assign pop               = out_bus.valid && out_bus.ready;

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      occ_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      occ_r <= occ_r + 2'(push) - 2'(pop);
    end
  end

  // No push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> occ_r != 2'd2)
    else $error("result queue overflow");

endmodule

`default_nettype wire

// ----- rtl/scan_count_pair_filter.sv -----
// ----------------------------------------------------------------------------
// scan_count_pair_filter
// Scan-count candidate pair generator for overlap set-similarity joins.
// ----------------------------------------------------------------------------
// Takes one posting-list entry per cycle while no sweep runs and the result
// queue has room: each entry reads the counter of other_id from a 4096-entry
// memory, adds one (saturating) and writes it back the next cycle, with the
// previous write forwarded when the same counter is hit twice in a row. A pair
// (other_id, probe_id) comes out when the count reaches overlap_threshold
// exactly and other_id < probe_id. Each counter carries a 16-bit probe
// generation mark, so new_probe clears all counters at once by advancing the
// mark. The input stalls after reset while the memory is zeroed, and for a
// sweep once every 65535 entries flagged new_probe, when stale marks are
// rewritten before the mark wraps. Threshold writes are taken at any time
// and count from the next entry.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_count_pair_filter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  scp_in_if.sink     in_bus,
  scp_out_if.source  out_bus,
  scp_cfg_if.sink    cfg_bus
);
  import scp_pkg::*;

  logic             in_fire;
  logic [THR_W-1:0] thr_r;
  epoch_t           epoch_r, epoch_nxt;
  epoch_t           mark_r;
  epoch_t           item_epoch;
  logic             sweep_start;
  swp_ctl_t         swp;

  logic             s1_valid_r;
  logic             s1_in_range_r;
  addr_t            s1_addr_r;
  id_t              s1_other_r;
  id_t              s1_probe_r;
  epoch_t           s1_epoch_r;

  mem_word_t        ram_rdata;
  logic             ram_we;
  addr_t            ram_waddr;
  mem_word_t        ram_wdata;
  logic             ram_re;
  addr_t            ram_raddr;

  logic             fw_valid_r;
  addr_t            fw_addr_r;
  mem_word_t        fw_data_r;

  mem_word_t        cur_word;
  cnt_t             eff_cnt;
  cnt_t             new_cnt;
  logic             item_we;
  logic             hit;
  pair_t            hit_pair;
  logic [1:0]       occ;
  logic             pop;

  // Threshold register
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_bus.valid) begin
      thr_r <= cfg_bus.data;
    end
  end

  // Accept while no sweep runs and the result queue has room for this beat
  assign in_bus.ready = !swp.busy &&
                        ((3'(occ) + 3'(s1_valid_r)) <= (3'd1 + 3'(pop)));
  assign in_fire      = in_bus.valid && in_bus.ready;

  // Advance the generation mark on a new probe
  assign item_epoch  = in_bus.new_probe ? epoch_r + 1'b1 : epoch_r;
  assign epoch_nxt   = in_fire ? item_epoch : epoch_r;
  assign sweep_start = in_fire && in_bus.new_probe &&
                       (epoch_t'(item_epoch + 1'b1) == mark_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= '0;
      mark_r  <= '0;
    end else begin
      epoch_r <= epoch_nxt;
      if (sweep_start) begin
        mark_r <= item_epoch;
      end
    end
  end

  scp_sweep u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sweep_start),
    .epoch   (epoch_r),
    .rd_data (ram_rdata),
    .ctl     (swp)
  );

  // Read stage: issue the counter read, hold the entry for write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_in_range_r <= (32'(in_bus.other_id) < NUM_SETS);
      s1_addr_r     <= ADDR_W'(in_bus.other_id);
      s1_other_r    <= in_bus.other_id;
      s1_probe_r    <= in_bus.probe_id;
      s1_epoch_r    <= item_epoch;
    end
  end

  assign ram_re    = in_fire || swp.rd_en;
  assign ram_raddr = in_fire ? ADDR_W'(in_bus.other_id) : swp.rd_addr;

  scp_count_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Update stage: forward last write, count, saturate, compare
  assign cur_word = (fw_valid_r && (fw_addr_r == s1_addr_r)) ? fw_data_r : ram_rdata;
  assign eff_cnt  = (cur_word.epoch == s1_epoch_r) ? cur_word.count : '0;
  assign new_cnt  = eff_cnt + 1'b1;
  assign item_we  = s1_valid_r && s1_in_range_r && (eff_cnt != CNT_MAX);
  assign hit      = item_we && (32'(new_cnt) == 32'(thr_r)) && (s1_other_r < s1_probe_r);
  assign hit_pair = '{pair_low: s1_other_r, pair_high: s1_probe_r};

  assign ram_we    = item_we || swp.wr_en;
  assign ram_waddr = item_we ? s1_addr_r : swp.wr_addr;
  assign ram_wdata = item_we ? mem_word_t'{epoch: s1_epoch_r, count: new_cnt} : swp.wr_data;

  // Hold the last entry write for the next read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_valid_r <= 1'b0;
    end else begin
      fw_valid_r <= item_we;
    end
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      fw_addr_r <= s1_addr_r;
      fw_data_r <= ram_wdata;
    end
  end

  scp_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (hit),
    .push_data (hit_pair),
    .occ       (occ),
    .pop       (pop),
    .out_bus   (out_bus)
  );

  // Entry write-back and sweep never share the write port
  a_wr_port: assert property (@(posedge clk) disable iff (!rst_n)
    item_we |-> !swp.wr_en)
    else $error("entry write collides with sweep write");

  // Generation mark moves only on an accepted new-probe beat
  a_epoch_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(epoch_r) |-> $past(in_fire && in_bus.new_probe))
    else $error("generation mark moved without a new probe");

  // Sweep reads happen only while the entry pipeline is idle
  a_sweep_read: assert property (@(posedge clk) disable iff (!rst_n)
    swp.rd_en |-> !s1_valid_r && !in_fire)
    else $error("sweep read overlaps entry traffic");

endmodule

`default_nettype wire
